// ----- sv/gbr_pkg.sv -----
`default_nettype none
package gbr_pkg;

    // frame limits and derived widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COORD_W    = 10;
    localparam int SIZE_W     = 11;
    localparam int SLOT_W     = 3;
    localparam int ADDR_W     = SLOT_W + COORD_W;
    localparam int ROWS       = 5;
    localparam int DEPTH      = ROWS * MAX_WIDTH;
    localparam int ACC_W      = 16;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;

    // controller to datapath
    typedef struct packed {
        logic store;
        logic start;
        logic tap;
        logic next;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic any;
        logic tap_last;
        logic out_last;
    } status_t;

    // one row of the binomial kernel
    function automatic logic [2:0] binom(input logic [2:0] k);
        logic [2:0] v;
        case (k)
            3'd0:    v = 3'd1;
            3'd1:    v = 3'd4;
            3'd2:    v = 3'd6;
            3'd3:    v = 3'd4;
            3'd4:    v = 3'd1;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // clamp a configured size into 1..limit
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] limit);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > limit)
            r = limit;
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/pixel_if.sv -----
`default_nettype none
interface pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;

    modport source (output valid, in_blue, in_green, in_red, input ready);
    modport sink (input valid, in_blue, in_green, in_red, output ready);
endinterface
`default_nettype wire

// ----- sv/result_if.sv -----
`default_nettype none
interface result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       last;

    modport source (output valid, out_blue, out_green, out_red, out_row, out_col, last,
                    input ready);
    modport sink (input valid, out_blue, out_green, out_red, out_row, out_col, last,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/gbr_datapath.sv -----
`default_nettype none
module gbr_datapath
    import gbr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data,
    input  wire logic [7:0]           in_blue,
    input  wire logic [7:0]           in_green,
    input  wire logic [7:0]           in_red,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    output logic [7:0]                out_blue,
    output logic [7:0]                out_green,
    output logic [7:0]                out_red,
    output logic [COORD_W-1:0]        out_row,
    output logic [COORD_W-1:0]        out_col
);

    logic [SIZE_W-1:0]  w_reg, h_reg;
    logic [COORD_W-1:0] row_reg, col_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [COORD_W-1:0] y_reg;
    logic [SLOT_W-1:0]  ys_reg;
    logic [COORD_W-1:0] r_lo_reg, r_hi_reg, c_lo_reg, c_hi_reg;
    logic               any_reg;
    logic [COORD_W-1:0] r_reg, c_reg;
    logic [2:0]         ky_reg, kx_reg;
    logic               rd_vld_reg;
    logic [5:0]         wt_reg;
    logic [23:0]        rd_data_reg;
    logic [ACC_W-1:0]   acc_b_reg, acc_g_reg, acc_r_reg;

    logic [23:0]        mem [0:DEPTH-1];

    logic [SIZE_W-1:0]  w1, h1;
    logic               x_end, y_end;
    logic [COORD_W-1:0] x_lo, y_lo;
    logic               any_next;
    logic [COORD_W-1:0] r_lo_next, r_hi_next, c_lo_next, c_hi_next;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic signed [SIZE_W:0] ty, tx;
    logic [COORD_W-1:0] yy, xx;
    logic [COORD_W-1:0] row_dist;
    logic [3:0]         slot_wrap;
    logic [SLOT_W-1:0]  rd_slot;
    logic [5:0]         wt_next;
    logic [ACC_W:0]     sum_b, sum_g, sum_r;

    // position decode for the incoming word
    always_comb
    begin
        w1    = w_reg - SIZE_W'(1);
        h1    = h_reg - SIZE_W'(1);
        x_end = ({1'b0, col_reg} == w1);
        y_end = ({1'b0, row_reg} == h1);
        x_lo  = (col_reg >= COORD_W'(2)) ? col_reg - COORD_W'(2) : '0;
        y_lo  = (row_reg >= COORD_W'(2)) ? row_reg - COORD_W'(2) : '0;
        c_lo_next = x_lo;
        c_hi_next = x_end ? col_reg : x_lo;
        r_lo_next = y_lo;
        r_hi_next = y_end ? row_reg : y_lo;
        any_next  = (x_end || col_reg >= COORD_W'(2)) && (y_end || row_reg >= COORD_W'(2));
        wr_addr   = {slot_reg, col_reg};
    end

    // configuration and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= WIDTH_RESET;
            h_reg    <= HEIGHT_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT))
        begin
            if (cfg_index == REG_WIDTH)
                w_reg <= eff_size(cfg_data, SIZE_W'(MAX_WIDTH));
            else
                h_reg <= eff_size(cfg_data, SIZE_W'(MAX_HEIGHT));
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cmd.store)
        begin
            if (x_end)
            begin
                col_reg <= '0;
                if (y_end)
                begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    row_reg  <= row_reg + COORD_W'(1);
                    slot_reg <= (slot_reg == SLOT_W'(ROWS - 1)) ? '0 : slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + COORD_W'(1);
            end
        end
    end

    // latch the window of outputs this word completes
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            y_reg    <= row_reg;
            ys_reg   <= slot_reg;
            r_lo_reg <= r_lo_next;
            r_hi_reg <= r_hi_next;
            c_lo_reg <= c_lo_next;
            c_hi_reg <= c_hi_next;
            any_reg  <= any_next;
        end
    end

    // output pixel and tap counters
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            r_reg <= r_lo_reg;
            c_reg <= c_lo_reg;
        end
        else if (cmd.next)
        begin
            if (c_reg == c_hi_reg)
            begin
                c_reg <= c_lo_reg;
                r_reg <= r_reg + COORD_W'(1);
            end
            else
            begin
                c_reg <= c_reg + COORD_W'(1);
            end
        end

        if (cmd.start || cmd.next)
        begin
            ky_reg <= '0;
            kx_reg <= '0;
        end
        else if (cmd.tap)
        begin
            if (kx_reg == 3'd4)
            begin
                kx_reg <= '0;
                ky_reg <= ky_reg + 3'd1;
            end
            else
            begin
                kx_reg <= kx_reg + 3'd1;
            end
        end
    end

    // tap address with edge replication
    always_comb
    begin
        ty = $signed({2'b00, r_reg}) + $signed({9'd0, ky_reg}) - (SIZE_W+1)'(2);
        tx = $signed({2'b00, c_reg}) + $signed({9'd0, kx_reg}) - (SIZE_W+1)'(2);
        if (ty < 0)
            yy = '0;
        else if (ty > $signed({1'b0, h1}))
            yy = h1[COORD_W-1:0];
        else
            yy = ty[COORD_W-1:0];
        if (tx < 0)
            xx = '0;
        else if (tx > $signed({1'b0, w1}))
            xx = w1[COORD_W-1:0];
        else
            xx = tx[COORD_W-1:0];
        // tap row sits 0..4 rows above the stored row
        row_dist  = y_reg - yy;
        slot_wrap = {1'b0, ys_reg} + 4'd5 - {1'b0, row_dist[SLOT_W-1:0]};
        rd_slot   = (ys_reg >= row_dist[SLOT_W-1:0]) ? ys_reg - row_dist[SLOT_W-1:0]
                                                     : slot_wrap[SLOT_W-1:0];
        rd_addr   = {rd_slot, xx};
        wt_next   = 6'(binom(ky_reg) * binom(kx_reg));
    end

    // line store
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[wr_addr] <= {in_red, in_green, in_blue};
        rd_data_reg <= mem[rd_addr];
        wt_reg      <= wt_next;
    end

    // multiply and accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= cmd.tap;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start || cmd.next)
        begin
            acc_b_reg <= '0;
            acc_g_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            acc_b_reg <= acc_b_reg + ACC_W'(wt_reg * rd_data_reg[7:0]);
            acc_g_reg <= acc_g_reg + ACC_W'(wt_reg * rd_data_reg[15:8]);
            acc_r_reg <= acc_r_reg + ACC_W'(wt_reg * rd_data_reg[23:16]);
        end
    end

    // round half up and scale by 1/256
    always_comb
    begin
        sum_b = {1'b0, acc_b_reg} + (ACC_W+1)'(128);
        sum_g = {1'b0, acc_g_reg} + (ACC_W+1)'(128);
        sum_r = {1'b0, acc_r_reg} + (ACC_W+1)'(128);
    end

    assign out_blue        = sum_b[15:8];
    assign out_green       = sum_g[15:8];
    assign out_red         = sum_r[15:8];
    assign out_row         = r_reg;
    assign out_col         = c_reg;
    assign status.any      = any_reg;
    assign status.tap_last = (ky_reg == 3'd4) && (kx_reg == 3'd4);
    assign status.out_last = (r_reg == r_hi_reg) && (c_reg == c_hi_reg);

endmodule
`default_nettype wire

// ----- sv/gbr_ctrl.sv -----
`default_nettype none
module gbr_ctrl
    import gbr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_TAPS  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.any)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_TAPS;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TAPS:
            begin
                cmd.tap = 1'b1;
                if (status.tap_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next   = 1'b1;
                        state_next = S_TAPS;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // accepted word is always followed by the window check
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CHECK))
        else $error("accepted word not followed by check");

    // the 25th tap drains before the word is shown
    a_taps_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAPS && status.tap_last) |=> (state_reg == S_DRAIN))
        else $error("tap sweep did not end in drain");

    // final result of a word returns to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.out_last) |=> (state_reg == S_IDLE))
        else $error("final result did not return to idle");

    // no input taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while result pending");

endmodule
`default_nettype wire

// ----- sv/gaussian_blur_5x5_replicate.sv -----
// channel   | dir | handshake     | payload
// pixel     | in  | valid / ready | in_blue, in_green, in_red
// blurred   | out | valid / ready | out_blue, out_green, out_red, out_row, out_col, last
// cfg       | in  | cfg_wr_en     | cfg_index, cfg_data (no read-back)
//
// a word is taken while idle, then the check state decides which outputs it completes
// each output takes 25 line-store reads through the single read port, then a drain state
//   for the accumulate, then it is shown on the output
// so one word completes n (0 to 9) outputs, and each of them can be held by output stalls
// rst_n is asynchronous; the line store is not cleared, every entry is written before read
// a stalled output holds the block; no input is taken until the last result is gone
`default_nettype none
module gaussian_blur_5x5_replicate
    import gbr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [SIZE_W-1:0]   cfg_data,
    pixel_if.sink                    pixel,
    result_if.source                 blurred
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    gbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .out_valid (blurred.valid),
        .out_ready (blurred.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // line store and filter arithmetic
    gbr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_blue   (pixel.in_blue),
        .in_green  (pixel.in_green),
        .in_red    (pixel.in_red),
        .cmd       (cmd),
        .status    (status),
        .out_blue  (blurred.out_blue),
        .out_green (blurred.out_green),
        .out_red   (blurred.out_red),
        .out_row   (blurred.out_row),
        .out_col   (blurred.out_col)
    );

    assign blurred.last = status.out_last;

endmodule
`default_nettype wire
